FILE: hdl/grms_pkg.sv
package grms_pkg;

    localparam int VW           = 48;
    localparam int IW           = 32;
    localparam int PW           = 96;
    localparam int NW           = 128;
    localparam int QW           = 112;
    localparam int CW           = 16;
    localparam int BLEND_ITERS  = 49;
    localparam int PROD_ITERS   = 63;
    localparam int STRESS_ITERS = 112;

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_SINGLE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [VW-1:0] MAX48 = 48'h7FFF_FFFF_FFFF;
    localparam logic [VW-1:0] MIN48 = 48'h8000_0000_0000;
    localparam logic [QW-1:0] LIM_POS = QW'(MAX48);
    localparam logic [QW-1:0] LIM_NEG = QW'(MIN48);

    typedef enum logic [1:0] {ST_OK, ST_ZERO, ST_ABSENT, ST_SAT} st_t;
    typedef enum logic [1:0] {X_RHO, X_MOM, X_QV} xsrc_t;
    typedef enum logic [1:0] {M_PROD, M_PRHO, M_AB, M_RR} msel_t;
    typedef enum logic [1:0] {D_BLEND, D_PROD, D_STRESS} dsel_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_SAMPLE, S_PMUL, S_PMUL_RUN, S_PDIV, S_PDIV_RUN,
        S_PSAT, S_RD, S_RDW, S_BDIV_RUN, S_WR, S_QRD, S_QCAP, S_QCHK,
        S_QMUL1, S_QMUL1_RUN, S_QMUL2, S_QMUL2_RUN, S_QMUL3, S_QMUL3_RUN,
        S_QDIV, S_QDIV_RUN, S_QFIN, S_DONE
    } state_t;

    typedef struct packed {
        logic       latch;
        logic [3:0] q;
        logic       qry;
        logic       load_x;
        xsrc_t      xsrc;
        logic       mul_start;
        msel_t      msel;
        logic       div_start;
        dsel_t      dsel;
        logic       prod_fin;
        logic       ram_wr;
        logic       cap_q;
        logic       cap_m1;
        logic       num_form;
        logic       stress_fin;
        logic       fin;
        st_t        code;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] rt;
        logic [3:0] qi;
        logic [2:0] comp;
        logic       rho_zero;
        logic       qrho_zero;
        logic       mul_busy;
        logic       div_busy;
    } dp_stat_t;

    function automatic logic [1:0] comp_a(input logic [2:0] c);
        case (c)
            3'd4:    return 2'd1;
            3'd2:    return 2'd1;
            3'd5:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] comp_b(input logic [2:0] c);
        case (c)
            3'd1:    return 2'd1;
            3'd2:    return 2'd1;
            3'd3:    return 2'd2;
            3'd4:    return 2'd2;
            3'd5:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [VW-1:0] mag48(input logic [VW-1:0] v);
        return v[VW-1] ? VW'(-v) : v;
    endfunction

endpackage

FILE: hdl/grms_ram.sv
module grms_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 5120
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hdl/grms_dp.sv
module grms_dp import grms_pkg::*; #(
    parameter int DIMS       = 3,
    parameter int SCALE_BITS = 3,
    parameter int NQUANT     = 10,
    parameter int ADDR_W     = 13
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic                     cfg_we,
    input  logic [CW-1:0]            cfg_data,
    input  logic [1:0]               req_type,
    input  logic [2:0]               pos_x,
    input  logic [2:0]               pos_y,
    input  logic [2:0]               pos_z,
    input  logic signed [IW-1:0]     density_in,
    input  logic signed [IW-1:0]     momentum_x,
    input  logic signed [IW-1:0]     momentum_y,
    input  logic signed [IW-1:0]     momentum_z,
    input  logic [3:0]               quantity_index,
    input  logic signed [IW-1:0]     quantity_value,
    input  logic [2:0]               stress_component,
    output logic [ADDR_W-1:0]        ram_addr,
    output logic                     ram_we,
    output logic [VW-1:0]            ram_wdata,
    input  logic [VW-1:0]            ram_rdata,
    output logic signed [VW-1:0]     stress_value,
    output logic [1:0]               status
);

    localparam int CELL_W = DIMS * SCALE_BITS;

    logic [1:0]        rt_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [IW-1:0]     rho_reg;
    logic [IW-1:0]     mom_reg [3];
    logic [3:0]        qi_reg;
    logic [IW-1:0]     qval_reg;
    logic [2:0]        comp_reg;
    logic [CW-1:0]     cnt_reg;
    logic [VW-1:0]     x_reg;
    logic [VW-1:0]     avg_reg;
    logic              dneg_reg;
    logic              psign_reg;
    logic              sat_reg;
    logic [VW-1:0]     qv_reg [4];
    logic [PW-1:0]     m1_reg;
    logic              m1sign_reg;
    logic [PW-1:0]     nmag_reg;
    logic              nneg_reg;
    logic [VW-1:0]     val_reg;
    st_t               status_reg;

    logic [VW-1:0]     mul_a_reg;
    logic [VW-1:0]     mul_b_reg;
    logic [PW-1:0]     acc_reg;
    logic              msign_reg;
    logic [1:0]        mcnt_reg;
    logic              mul_busy_reg;

    logic [NW-1:0]     dnum_reg;
    logic [PW:0]       drem_reg;
    logic [PW-1:0]     dden_reg;
    logic [QW-1:0]     quot_reg;
    logic [6:0]        dcnt_reg;
    logic              div_busy_reg;

    logic [4:0]                px, py, pz;
    logic [3*SCALE_BITS-1:0]   cell_all;
    logic [ADDR_W-1:0]         base_next;
    logic [3:0]                off;
    logic [1:0]                mi;
    logic [2:0]                pc;
    logic [VW-1:0]             op_a, op_b;
    logic [63:0]               pp;
    logic signed [VW:0]        diff;
    logic [VW:0]               dmag;
    logic [16:0]               cnt1;
    logic [PW:0]               rem_sh;
    logic [PW+1:0]             sub;
    logic                      ge;
    logic                      fin_sign;
    logic                      over;
    logic [VW-1:0]             sres;
    logic signed [VW:0]        step49;
    logic signed [VW:0]        new49;
    logic signed [PW+1:0]      t1, t2, numv;

    always_comb
    begin
        px        = 5'(pos_x);
        py        = 5'(pos_y);
        pz        = 5'(pos_z);
        cell_all  = {pz[SCALE_BITS-1:0], py[SCALE_BITS-1:0], px[SCALE_BITS-1:0]};
        base_next = ADDR_W'(cell_all[CELL_W-1:0]) * ADDR_W'(NQUANT);
    end

    always_comb
    begin
        if (cmd.qry)
        begin
            case (cmd.q[1:0])
                2'd0:    off = 4'd0;
                2'd1:    off = 4'd1 + 4'(comp_a(comp_reg));
                2'd2:    off = 4'd1 + 4'(comp_b(comp_reg));
                default: off = 4'(1 + DIMS) + 4'(comp_reg);
            endcase
        end
        else
        begin
            off = cmd.q;
        end
    end

    assign ram_addr = base_reg + ADDR_W'(off);
    assign ram_we   = cmd.ram_wr;

    assign mi = 2'(cmd.q - 4'd1);
    assign pc = 3'(cmd.q - 4'd1 - 4'(DIMS));

    always_comb
    begin
        case (cmd.msel)
            M_PROD:
            begin
                op_a = {{16{mom_reg[comp_a(pc)][IW-1]}}, mom_reg[comp_a(pc)]};
                op_b = {{16{mom_reg[comp_b(pc)][IW-1]}}, mom_reg[comp_b(pc)]};
            end
            M_PRHO:
            begin
                op_a = qv_reg[3];
                op_b = qv_reg[0];
            end
            M_AB:
            begin
                op_a = qv_reg[1];
                op_b = qv_reg[2];
            end
            default:
            begin
                op_a = qv_reg[0];
                op_b = qv_reg[0];
            end
        endcase
    end

    assign pp = mul_a_reg * mul_b_reg[VW-1:VW-16];

    assign diff = $signed({x_reg[VW-1], x_reg}) - $signed({ram_rdata[VW-1], ram_rdata});
    assign dmag = diff[VW] ? (VW+1)'(-diff) : (VW+1)'(diff);
    assign cnt1 = {1'b0, cnt_reg} + 17'd1;

    assign rem_sh = {drem_reg[PW-1:0], dnum_reg[NW-1]};
    assign sub    = {1'b0, rem_sh} - {2'b0, dden_reg};
    assign ge     = ~sub[PW+1];

    assign fin_sign = cmd.stress_fin ? nneg_reg : psign_reg;
    assign over     = fin_sign ? (quot_reg > LIM_NEG) : (quot_reg > LIM_POS);
    always_comb
    begin
        if (over)
        begin
            sres = fin_sign ? MIN48 : MAX48;
        end
        else
        begin
            sres = fin_sign ? VW'(-quot_reg[VW-1:0]) : quot_reg[VW-1:0];
        end
    end

    assign step49    = dneg_reg ? $signed(-quot_reg[VW:0]) : $signed(quot_reg[VW:0]);
    assign new49     = $signed({avg_reg[VW-1], avg_reg}) + step49;
    assign ram_wdata = (cnt_reg == '0) ? x_reg : new49[VW-1:0];

    assign t1   = m1sign_reg ? -$signed({2'b0, m1_reg}) : $signed({2'b0, m1_reg});
    assign t2   = msign_reg ? -$signed({2'b0, acc_reg}) : $signed({2'b0, acc_reg});
    assign numv = t1 - t2;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            rt_reg     <= req_type;
            base_reg   <= base_next;
            rho_reg    <= density_in;
            mom_reg[0] <= momentum_x;
            mom_reg[1] <= (DIMS > 1) ? momentum_y : '0;
            mom_reg[2] <= (DIMS > 2) ? momentum_z : '0;
            qi_reg     <= quantity_index;
            qval_reg   <= quantity_value;
            comp_reg   <= stress_component;
            val_reg    <= '0;
            sat_reg    <= 1'b0;
        end
        if (cmd.load_x)
        begin
            case (cmd.xsrc)
                X_RHO:   x_reg <= {{16{rho_reg[IW-1]}}, rho_reg};
                X_MOM:   x_reg <= {{16{mom_reg[mi][IW-1]}}, mom_reg[mi]};
                default: x_reg <= {{16{qval_reg[IW-1]}}, qval_reg};
            endcase
        end
        if (cmd.prod_fin)
        begin
            x_reg <= sres;
            if (over)
            begin
                sat_reg <= 1'b1;
            end
        end
        if (cmd.cap_q)
        begin
            qv_reg[cmd.q[1:0]] <= ram_rdata;
        end
        if (cmd.cap_m1)
        begin
            m1_reg     <= acc_reg;
            m1sign_reg <= msign_reg;
        end
        if (cmd.num_form)
        begin
            nneg_reg <= numv[PW+1];
            nmag_reg <= numv[PW+1] ? PW'(-numv) : PW'(numv);
        end
        if (cmd.stress_fin)
        begin
            val_reg <= sres;
        end
        if (cmd.fin)
        begin
            if (cmd.code == ST_OK && (sat_reg || (cmd.stress_fin && over)))
            begin
                status_reg <= ST_SAT;
            end
            else
            begin
                status_reg <= cmd.code;
            end
        end

        if (cmd.mul_start)
        begin
            mul_a_reg <= mag48(op_a);
            mul_b_reg <= mag48(op_b);
            msign_reg <= op_a[VW-1] ^ op_b[VW-1];
            acc_reg   <= '0;
        end
        else if (mul_busy_reg)
        begin
            acc_reg   <= {acc_reg[PW-17:0], 16'b0} + PW'(pp);
            mul_b_reg <= {mul_b_reg[VW-17:0], 16'b0};
        end

        if (cmd.div_start)
        begin
            drem_reg <= '0;
            quot_reg <= '0;
            case (cmd.dsel)
                D_BLEND:
                begin
                    dnum_reg <= {dmag, (NW-VW-1)'(0)};
                    dden_reg <= PW'(cnt1);
                    avg_reg  <= ram_rdata;
                    dneg_reg <= diff[VW];
                end
                D_PROD:
                begin
                    dnum_reg  <= {acc_reg[PROD_ITERS-1:0], (NW-PROD_ITERS)'(0)};
                    dden_reg  <= PW'(rho_reg[IW-1] ? IW'(-rho_reg) : rho_reg);
                    psign_reg <= msign_reg ^ rho_reg[IW-1];
                end
                default:
                begin
                    dnum_reg <= {nmag_reg, (NW-PW)'(0)};
                    dden_reg <= acc_reg;
                end
            endcase
        end
        else if (div_busy_reg)
        begin
            drem_reg <= ge ? sub[PW:0] : rem_sh;
            quot_reg <= {quot_reg[QW-2:0], ge};
            dnum_reg <= {dnum_reg[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            mul_busy_reg <= 1'b0;
            mcnt_reg     <= '0;
            div_busy_reg <= 1'b0;
            dcnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cnt_reg <= cfg_data;
            end
            if (cmd.mul_start)
            begin
                mul_busy_reg <= 1'b1;
                mcnt_reg     <= 2'd2;
            end
            else if (mul_busy_reg)
            begin
                mcnt_reg <= mcnt_reg - 2'd1;
                if (mcnt_reg == 2'd0)
                begin
                    mul_busy_reg <= 1'b0;
                end
            end
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                case (cmd.dsel)
                    D_BLEND: dcnt_reg <= 7'(BLEND_ITERS - 1);
                    D_PROD:  dcnt_reg <= 7'(PROD_ITERS - 1);
                    default: dcnt_reg <= 7'(STRESS_ITERS - 1);
                endcase
            end
            else if (div_busy_reg)
            begin
                dcnt_reg <= dcnt_reg - 7'd1;
                if (dcnt_reg == 7'd0)
                begin
                    div_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        stat.rt        = rt_reg;
        stat.qi        = qi_reg;
        stat.comp      = comp_reg;
        stat.rho_zero  = (rho_reg == '0);
        stat.qrho_zero = (qv_reg[0] == '0);
        stat.mul_busy  = mul_busy_reg;
        stat.div_busy  = div_busy_reg;
    end

    assign stress_value = val_reg;
    assign status       = status_reg;

endmodule

FILE: hdl/grms_ctrl.sv
module grms_ctrl import grms_pkg::*; #(
    parameter int DIMS   = 3,
    parameter int NQUANT = 10,
    parameter int NCOMP  = 6
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t     state_reg, state_next;
    logic [3:0] q_reg, q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            q_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            q_reg     <= q_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.q      = q_reg;
        state_next = state_reg;
        q_next     = q_reg;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.rt)
                    REQ_UPDATE:
                    begin
                        if (stat.rho_zero)
                        begin
                            cmd.fin    = 1'b1;
                            cmd.code   = ST_ZERO;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            q_next     = '0;
                            state_next = S_SAMPLE;
                        end
                    end
                    REQ_SINGLE:
                    begin
                        if (stat.qi >= 4'(NQUANT))
                        begin
                            cmd.fin    = 1'b1;
                            cmd.code   = ST_ABSENT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            q_next     = stat.qi;
                            cmd.load_x = 1'b1;
                            cmd.xsrc   = X_QV;
                            state_next = S_RD;
                        end
                    end
                    REQ_QUERY:
                    begin
                        if (stat.comp >= 3'(NCOMP))
                        begin
                            cmd.fin    = 1'b1;
                            cmd.code   = ST_ABSENT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            q_next     = '0;
                            state_next = S_QRD;
                        end
                    end
                    default:
                    begin
                        cmd.fin    = 1'b1;
                        cmd.code   = ST_ABSENT;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SAMPLE:
            begin
                if (q_reg == '0)
                begin
                    cmd.load_x = 1'b1;
                    cmd.xsrc   = X_RHO;
                    state_next = S_RD;
                end
                else if (q_reg <= 4'(DIMS))
                begin
                    cmd.load_x = 1'b1;
                    cmd.xsrc   = X_MOM;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_PMUL;
                end
            end
            S_PMUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.msel      = M_PROD;
                state_next    = S_PMUL_RUN;
            end
            S_PMUL_RUN:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = S_PDIV;
                end
            end
            S_PDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.dsel      = D_PROD;
                state_next    = S_PDIV_RUN;
            end
            S_PDIV_RUN:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_PSAT;
                end
            end
            S_PSAT:
            begin
                cmd.prod_fin = 1'b1;
                state_next   = S_RD;
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                cmd.div_start = 1'b1;
                cmd.dsel      = D_BLEND;
                state_next    = S_BDIV_RUN;
            end
            S_BDIV_RUN:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                cmd.ram_wr = 1'b1;
                if (stat.rt == REQ_UPDATE && q_reg != 4'(NQUANT - 1))
                begin
                    q_next     = q_reg + 4'd1;
                    state_next = S_SAMPLE;
                end
                else
                begin
                    cmd.fin    = 1'b1;
                    cmd.code   = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_QRD:
            begin
                cmd.qry    = 1'b1;
                state_next = S_QCAP;
            end
            S_QCAP:
            begin
                cmd.qry   = 1'b1;
                cmd.cap_q = 1'b1;
                if (q_reg == 4'd3)
                begin
                    state_next = S_QCHK;
                end
                else
                begin
                    q_next     = q_reg + 4'd1;
                    state_next = S_QRD;
                end
            end
            S_QCHK:
            begin
                if (stat.qrho_zero)
                begin
                    cmd.fin    = 1'b1;
                    cmd.code   = ST_ZERO;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_QMUL1;
                end
            end
            S_QMUL1:
            begin
                cmd.mul_start = 1'b1;
                cmd.msel      = M_PRHO;
                state_next    = S_QMUL1_RUN;
            end
            S_QMUL1_RUN:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = S_QMUL2;
                end
            end
            S_QMUL2:
            begin
                cmd.cap_m1    = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.msel      = M_AB;
                state_next    = S_QMUL2_RUN;
            end
            S_QMUL2_RUN:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = S_QMUL3;
                end
            end
            S_QMUL3:
            begin
                cmd.num_form  = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.msel      = M_RR;
                state_next    = S_QMUL3_RUN;
            end
            S_QMUL3_RUN:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.dsel      = D_STRESS;
                state_next    = S_QDIV_RUN;
            end
            S_QDIV_RUN:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_QFIN;
                end
            end
            S_QFIN:
            begin
                cmd.stress_fin = 1'b1;
                cmd.fin        = 1'b1;
                cmd.code       = ST_OK;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: hdl/grid_running_mean_reynolds_stress_core.sv
// Running means per grid cell with Reynolds-stress readout.
// Items: drive the request fields with start high; the item is taken on a
// rising edge where start is high and busy is low. busy stays high until the
// result has been shown. done marks the result (stress_value, status) and is
// high for a single cycle; the receiver cannot hold it off.
// sample_count is written on the cfg channel (cfg_valid/cfg_ready, ready
// while idle); it never advances by itself.
// The shared divider yields one quotient bit per cycle and the multiplier
// works in 16-bit digits; together they set how long a density or momentum
// blend, a flux product, a full 3-D update, a single-quantity update and a
// stress query take. A rejected item goes from accept straight to done.
// One item is worked on at a time; the next is taken the cycle after done.
// Reset clears sample_count and the sequencer; the mean store is not
// cleared, and a sweep with sample_count 0 defines it.
module grid_running_mean_reynolds_stress_core import grms_pkg::*; #(
    parameter int DIMS       = 3,
    parameter int SCALE_BITS = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CW-1:0]        cfg_data,
    input  logic [1:0]           req_type,
    input  logic [2:0]           pos_x,
    input  logic [2:0]           pos_y,
    input  logic [2:0]           pos_z,
    input  logic signed [IW-1:0] density_in,
    input  logic signed [IW-1:0] momentum_x,
    input  logic signed [IW-1:0] momentum_y,
    input  logic signed [IW-1:0] momentum_z,
    input  logic [3:0]           quantity_index,
    input  logic signed [IW-1:0] quantity_value,
    input  logic [2:0]           stress_component,
    output logic signed [VW-1:0] stress_value,
    output logic [1:0]           status
);

    localparam int NQUANT = (DIMS == 1) ? 3 : ((DIMS == 2) ? 6 : 10);
    localparam int NCOMP  = DIMS * (DIMS + 1) / 2;
    localparam int DEPTH  = (1 << (DIMS * SCALE_BITS)) * NQUANT;
    localparam int ADDR_W = $clog2(DEPTH);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [VW-1:0]     ram_wdata;
    logic [VW-1:0]     ram_rdata;

    assign cfg_ready = ~busy;

    grms_ctrl #(
        .DIMS   (DIMS),
        .NQUANT (NQUANT),
        .NCOMP  (NCOMP)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    grms_dp #(
        .DIMS       (DIMS),
        .SCALE_BITS (SCALE_BITS),
        .NQUANT     (NQUANT),
        .ADDR_W     (ADDR_W)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_valid & cfg_ready),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .density_in       (density_in),
        .momentum_x       (momentum_x),
        .momentum_y       (momentum_y),
        .momentum_z       (momentum_z),
        .quantity_index   (quantity_index),
        .quantity_value   (quantity_value),
        .stress_component (stress_component),
        .ram_addr         (ram_addr),
        .ram_we           (ram_we),
        .ram_wdata        (ram_wdata),
        .ram_rdata        (ram_rdata),
        .stress_value     (stress_value),
        .status           (status)
    );

    grms_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule
